### rtl/core/dad_pkg.sv
// Package for the date adder: field widths, sequencer state and control types,
// and the month-length and leap-year helpers.
// Used by every module in rtl/core; it depends on nothing.
package dad_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned RemW   = 9;   // holds a year modulo 400
  localparam int unsigned StepW  = 3;

  localparam int unsigned YearMod  = 400;
  localparam int unsigned RemSteps = 6;  // 400 << 5 is the largest divisor step
  localparam int unsigned LeapDays = 29;
  localparam int unsigned FebDays  = 28;

  localparam logic [MonW-1:0]  MonJan  = 4'd1;
  localparam logic [MonW-1:0]  MonFeb  = 4'd2;
  localparam logic [MonW-1:0]  MonDec  = 4'd12;
  localparam logic [YearW-1:0] YearTop = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_CLAMP,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             rem;
    logic             clamp;
    logic             walk;
    logic [StepW-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

  // Leap rule on a year already reduced modulo 400.
  function automatic logic is_leap(logic [RemW-1:0] r);
    logic cent;
    cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                       len = leap ? DayW'(LeapDays) : DayW'(FebDays);
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/dad_sub.sv
// Shared subtract-and-compare unit of the date adder.
// Depends on dad_pkg for the operand width.
module dad_sub
  import dad_pkg::*;
(
  input  logic [CountW-1:0] a_i,
  input  logic [CountW-1:0] b_i,
  output logic [CountW-1:0] diff_o,
  output logic              borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

### rtl/core/dad_ctrl.sv
// Sequencer of the date adder: load, reduce the year, clamp, walk months, deliver.
// Depends on dad_pkg for the state enum and the control structs.
module dad_ctrl
  import dad_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_ready_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    in_ready_o,
  output logic    out_valid_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_REM;
          step_d  = StepW'(RemSteps - 1);
        end
      end
      ST_REM: begin
        if (step_q == '0) begin
          state_d = ST_CLAMP;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_CLAMP: state_d = ST_WALK;
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.step = step_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_REM:   ctrl_o.rem   = 1'b1;
      ST_CLAMP: ctrl_o.clamp = 1'b1;
      ST_WALK:  ctrl_o.walk  = 1'b1;
      ST_DONE:  out_valid_o  = 1'b1;
      default:  ;
    endcase
  end

endmodule

### rtl/core/dad_dpath.sv
// Datapath of the date adder: date and count registers, year-mod-400 tracker,
// and the operand selection around the shared subtract unit.
// Depends on dad_pkg and instantiates dad_sub.
module dad_dpath
  import dad_pkg::*;
(
  input  logic              clk_i,
  input  ctrl_t             ctrl_i,
  input  logic [DayW-1:0]   start_day_i,
  input  logic [MonW-1:0]   start_month_i,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [CountW-1:0] days_to_add_i,
  output status_t           status_o,
  output logic [DayW-1:0]   end_day_o,
  output logic [MonW-1:0]   end_month_o,
  output logic [YearW-1:0]  end_year_o
);

  logic [DayW-1:0]   day_q, day_d;
  logic [MonW-1:0]   mon_q, mon_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [YearW-1:0]  rem_q, rem_d;

  logic [CountW-1:0] sub_a, sub_b, sub_diff;
  logic              sub_borrow;
  logic              leap;
  logic [DayW-1:0]   len, left;
  logic [MonW-1:0]   mon_in;

  assign leap = is_leap(rem_q[RemW-1:0]);
  assign len  = month_len(mon_q, leap);
  assign left = len - day_q;

  always_comb begin
    if (start_month_i < MonJan) begin
      mon_in = MonJan;
    end else if (start_month_i > MonDec) begin
      mon_in = MonDec;
    end else begin
      mon_in = start_month_i;
    end
  end

  // During the year reduction the unit does one restoring step of rem - (400 << k);
  // during the walk it compares the count against the days left plus one.
  always_comb begin
    if (ctrl_i.rem) begin
      sub_a = CountW'(rem_q);
      sub_b = CountW'(YearMod) << ctrl_i.step;
    end else begin
      sub_a = cnt_q;
      sub_b = CountW'(left) + 1'b1;
    end
  end

  dad_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign status_o.walk_done = sub_borrow;

  always_comb begin
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    if (ctrl_i.load) begin
      day_d  = start_day_i;
      mon_d  = mon_in;
      year_d = start_year_i;
      cnt_d  = days_to_add_i;
      rem_d  = start_year_i;
    end else if (ctrl_i.rem) begin
      if (!sub_borrow) begin
        rem_d = sub_diff[YearW-1:0];
      end
    end else if (ctrl_i.clamp) begin
      if (day_q == '0) begin
        day_d = 5'd1;
      end else if (day_q > len) begin
        day_d = len;
      end
    end else if (ctrl_i.walk) begin
      if (sub_borrow) begin
        // The count fits inside this month, so it is below 31.
        day_d = day_q + cnt_q[DayW-1:0];
        cnt_d = '0;
      end else begin
        cnt_d = sub_diff;
        day_d = 5'd1;
        if (mon_q == MonDec) begin
          mon_d  = MonJan;
          year_d = year_q + 1'b1;
          // The 14-bit year wraps to zero, which is a multiple of 400.
          if (year_q == YearTop || rem_q == YearW'(YearMod - 1)) begin
            rem_d = '0;
          end else begin
            rem_d = rem_q + 1'b1;
          end
        end else begin
          mon_d = mon_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
  end

  assign end_day_o   = day_q;
  assign end_month_o = mon_q;
  assign end_year_o  = year_q;

endmodule

### rtl/core/date_add_days.sv
// Top level of the date adder: stream ports, sequencer and datapath.
// Depends on dad_pkg; instantiates dad_ctrl and dad_dpath.
//
//   channel  dir  beat contents
//   s_axis   in   start date and day count
//   m_axis   out  resulting date
//
// Each beat first reduces the year modulo 400 on the shared subtract unit, then
// clamps the day and walks the months on the same unit, one month per cycle.
// s_axis_tready is high only while the block is idle; the result is held on
// m_axis until it is taken, and a new beat is accepted the cycle after.
// Reset clears the sequencer only; the datapath holds no state between beats.
module date_add_days
  import dad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // start_day, start_month, start_year, days_to_add
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // end_day, end_month, end_year
);

  ctrl_t   ctrl;
  status_t status;

  logic [DayW-1:0]  end_day;
  logic [MonW-1:0]  end_month;
  logic [YearW-1:0] end_year;

  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .ctrl_o      (ctrl),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  dad_dpath u_dpath (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .start_day_i   (s_axis_tdata[4:0]),
    .start_month_i (s_axis_tdata[8:5]),
    .start_year_i  (s_axis_tdata[22:9]),
    .days_to_add_i (s_axis_tdata[38:23]),
    .status_o      (status),
    .end_day_o     (end_day),
    .end_month_o   (end_month),
    .end_year_o    (end_year)
  );

  assign m_axis_tdata = {1'b0, end_year, end_month, end_day};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after an accepted beat");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (end_month >= MonJan && end_month <= MonDec))
    else $error("result month out of range");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (end_day != '0))
    else $error("result day is zero");
`endif

endmodule
